// ===== sv/b2r_pkg.sv =====
// ----------------------------------------------------------------------------
// b2r_pkg
// Shared types, constants and symbol table for the binary to Roman numeral
// converter.
// ----------------------------------------------------------------------------
package b2r_pkg;

   // field widths
   localparam int ValueWidth  = 12;
   localparam int SymbolWidth = 8;
   localparam int ReqDataWidth = 16;   // value padded to whole bytes
   localparam int RspDataWidth = 8;

   // largest value that has a numeral
   localparam logic [ValueWidth-1:0] VALUE_MAX = 12'd3999;

   // ASCII codes
   localparam logic [SymbolWidth-1:0] CH_NONE = 8'h00;
   localparam logic [SymbolWidth-1:0] CH_I    = 8'h49;
   localparam logic [SymbolWidth-1:0] CH_V    = 8'h56;
   localparam logic [SymbolWidth-1:0] CH_X    = 8'h58;
   localparam logic [SymbolWidth-1:0] CH_L    = 8'h4C;
   localparam logic [SymbolWidth-1:0] CH_C    = 8'h43;
   localparam logic [SymbolWidth-1:0] CH_D    = 8'h44;
   localparam logic [SymbolWidth-1:0] CH_M    = 8'h4D;

   // symbol table: 13 entries, largest weight first
   localparam int NumEntries = 13;
   localparam int IdxWidth   = $clog2(NumEntries);

   typedef logic [IdxWidth-1:0]    idx_type;
   typedef logic [ValueWidth-1:0]  value_type;
   typedef logic [SymbolWidth-1:0] symbol_type;

   // controller to datapath
   typedef struct packed {
      logic load;          // take a new value
      logic emit_first;    // produce next entry's first (or only) character
      logic emit_second;   // produce second character of a subtractive pair
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic oor;           // loaded value has no numeral
      logic pair;          // selected entry is a two-character pair
      logic fin_first;     // first-character step ends the numeral
      logic fin_second;    // second-character step ends the numeral
   } status_type;

   function automatic value_type sym_weight(input idx_type idx);
      value_type w;
      case (idx)
         4'd0:    w = 12'd1000;
         4'd1:    w = 12'd900;
         4'd2:    w = 12'd500;
         4'd3:    w = 12'd400;
         4'd4:    w = 12'd100;
         4'd5:    w = 12'd90;
         4'd6:    w = 12'd50;
         4'd7:    w = 12'd40;
         4'd8:    w = 12'd10;
         4'd9:    w = 12'd9;
         4'd10:   w = 12'd5;
         4'd11:   w = 12'd4;
         4'd12:   w = 12'd1;
         default: w = 12'd1;
      endcase
      return w;
   endfunction

   function automatic symbol_type sym_first(input idx_type idx);
      symbol_type s;
      case (idx)
         4'd0:    s = CH_M;
         4'd1:    s = CH_C;
         4'd2:    s = CH_D;
         4'd3:    s = CH_C;
         4'd4:    s = CH_C;
         4'd5:    s = CH_X;
         4'd6:    s = CH_L;
         4'd7:    s = CH_X;
         4'd8:    s = CH_X;
         4'd9:    s = CH_I;
         4'd10:   s = CH_V;
         4'd11:   s = CH_I;
         4'd12:   s = CH_I;
         default: s = CH_NONE;
      endcase
      return s;
   endfunction

   function automatic symbol_type sym_second(input idx_type idx);
      symbol_type s;
      case (idx)
         4'd1:    s = CH_M;
         4'd3:    s = CH_D;
         4'd5:    s = CH_C;
         4'd7:    s = CH_L;
         4'd9:    s = CH_X;
         4'd11:   s = CH_V;
         default: s = CH_NONE;
      endcase
      return s;
   endfunction

   function automatic logic sym_is_pair(input idx_type idx);
      logic p;
      case (idx)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11: p = 1'b1;
         default:                             p = 1'b0;
      endcase
      return p;
   endfunction

endpackage

// ===== sv/binary_to_roman_numeral.sv =====
// On acceptance the value is loaded into the remainder register; the numeral's
// characters are then registered into the output register, one character per
// cycle while rsp_tready does not hold one back. A numeral has 1 to 15
// characters; an out-of-range value gives one error item. A new item is
// accepted only once the last character of the current item has been registered.
// Reset: synchronous, active high; clears the controller state and rsp_tvalid.
// ----------------------------------------------------------------------------
// binary_to_roman_numeral
// Converts a 12-bit binary number into its Roman numeral, one ASCII character
// per output item, the final one marked by rsp_tlast.
// ----------------------------------------------------------------------------
module binary_to_roman_numeral
   import b2r_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,   // [11:0] value, [15:12] zero
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // [7:0] symbol
   output logic                    rsp_tlast,   // last
   output logic                    rsp_tuser    // [0] out_of_range
);

   cmd_type    cmd;
   status_type status;

   b2r_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   b2r_dp u_dp (
      .clock        (clock),
      .value        (req_tdata[ValueWidth-1:0]),
      .cmd          (cmd),
      .status       (status),
      .symbol       (rsp_tdata),
      .last         (rsp_tlast),
      .out_of_range (rsp_tuser)
   );

endmodule

// ===== sv/b2r_dp.sv =====
// ----------------------------------------------------------------------------
// b2r_dp
// Datapath: remainder register, largest-symbol search, character and
// output registers.
// ----------------------------------------------------------------------------
module b2r_dp
   import b2r_pkg::*;
(
   input  logic       clock,
   input  value_type  value,
   input  cmd_type    cmd,
   output status_type status,
   output symbol_type symbol,
   output logic       last,
   output logic       out_of_range
);

   value_type  rem_ff,  rem_in;
   logic       oor_ff,  oor_in;
   idx_type    sel_ff,  sel_in;
   symbol_type sym_ff,  sym_in;
   logic       last_ff, last_in;
   logic       err_ff,  err_in;

   idx_type    idx;
   value_type  rem_first;
   value_type  rem_second;

   // largest table weight not above the remainder
   always_comb begin
      idx = idx_type'(NumEntries - 1);
      for (int i = NumEntries - 1; i >= 0; i--) begin
         if (rem_ff >= sym_weight(idx_type'(i))) begin
            idx = idx_type'(i);
         end
      end
   end

   assign rem_first  = rem_ff - sym_weight(idx);
   assign rem_second = rem_ff - sym_weight(sel_ff);

   assign status.oor        = oor_ff;
   assign status.pair       = sym_is_pair(idx);
   assign status.fin_first  = oor_ff | (~sym_is_pair(idx) & (rem_first == '0));
   assign status.fin_second = (rem_second == '0);

   // next values
   always_comb begin
      rem_in  = rem_ff;
      oor_in  = oor_ff;
      sel_in  = sel_ff;
      sym_in  = sym_ff;
      last_in = last_ff;
      err_in  = err_ff;
      if (cmd.load) begin
         rem_in = value;
         oor_in = (value == '0) | (value > VALUE_MAX);
      end
      if (cmd.emit_first) begin
         sel_in  = idx;
         sym_in  = oor_ff ? CH_NONE : sym_first(idx);
         last_in = status.fin_first;
         err_in  = oor_ff;
         if (!oor_ff && !sym_is_pair(idx)) begin
            rem_in = rem_first;
         end
      end
      if (cmd.emit_second) begin
         sym_in  = sym_second(sel_ff);
         last_in = status.fin_second;
         err_in  = 1'b0;
         rem_in  = rem_second;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      oor_ff  <= oor_in;
      sel_ff  <= sel_in;
      sym_ff  <= sym_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign symbol       = sym_ff;
   assign last         = last_ff;
   assign out_of_range = err_ff;

endmodule

// ===== sv/b2r_ctrl.sv =====
// ----------------------------------------------------------------------------
// b2r_ctrl
// Controller: input handshake, character sequencing and output valid.
// ----------------------------------------------------------------------------
module b2r_ctrl
   import b2r_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_EMIT2
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // output register can take a character this cycle
   assign out_free = ~rsp_valid_ff | rsp_tready;

   assign req_tready      = (state_ff == ST_IDLE);
   assign cmd.load        = req_tready & req_tvalid;
   assign cmd.emit_first  = (state_ff == ST_EMIT) & out_free;
   assign cmd.emit_second = (state_ff == ST_EMIT2) & out_free;

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (cmd.emit_first) begin
                  if (status.fin_first) begin
                     state_ff <= ST_IDLE;
                  end else if (status.pair) begin
                     state_ff <= ST_EMIT2;
                  end
               end
            end
            ST_EMIT2: begin
               if (cmd.emit_second) begin
                  state_ff <= status.fin_second ? ST_IDLE : ST_EMIT;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (cmd.emit_first || cmd.emit_second) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/b2r_check.sv =====
// ----------------------------------------------------------------------------
// b2r_check
// Port-level checks for binary_to_roman_numeral, bound to the top level.
// ----------------------------------------------------------------------------
module b2r_check
   import b2r_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic                    rsp_tlast,
   input logic                    rsp_tuser
);

   // an error item is a lone zero character that ends its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == CH_NONE))
      else $error("error item not a lone zero character");

   // a normal item always carries a real character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata != CH_NONE))
      else $error("zero character without error flag");

   // one item at a time: no new item right after one is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after accept");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind binary_to_roman_numeral b2r_check u_b2r_check (.*);

// ===== verif/binary_to_roman_numeral_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_tb
// Self-checking bench for the Roman numeral converter. A short table of
// directed values comes first: limits, the longest numeral, every digit shape
// and out-of-range codes, some with the numeral typed in. Random values
// follow. Every character on the result stream is compared against a
// behavioral model of the conversion. Both streams stall at random.
// ----------------------------------------------------------------------------
module binary_to_roman_numeral_tb
   import b2r_pkg::*;
;

   localparam int NumRows     = 24;
   localparam int RandomItems = 136;

   // one expected character on the result stream
   typedef struct packed {
      symbol_type symbol;
      logic       last;
      logic       oor;
   } numeral_char_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;

   numeral_char_type numeral_chars[$];   // characters still owed by the block
   bit               no_stall;           // quiet stretch: neither side idles
   int               mismatches;
   int               values_sent;
   int               oor_sent;
   int               chars_seen;

   // Directed values. Text column: "" = use the model, "#" = out-of-range
   // item, anything else is the numeral itself.
   value_type row_value [NumRows] = '{
      12'd1,    12'd3999, 12'd0,    12'd4000, 12'd4095, 12'd3888,
      12'd4,    12'd9,    12'd5,    12'd3,    12'd10,   12'd1000,
      12'd8,    12'd40,   12'd90,   12'd400,  12'd900,  12'd50,
      12'd500,  12'd2444, 12'd1994, 12'd606,  12'd2730, 12'd1365
   };
   string row_text [NumRows] = '{
      "I",      "MMMCMXCIX", "#",     "#",      "#",      "MMMDCCCLXXXVIII",
      "IV",     "IX",        "V",     "III",    "X",      "M",
      "",       "",          "",      "",       "",       "",
      "",       "",          "",      "",       "",       ""
   };

   binary_to_roman_numeral i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // one decimal digit with its one-, five- and ten-symbols
   function automatic void add_digit(ref symbol_type syms[$], input int d,
                                     input symbol_type one, input symbol_type five,
                                     input symbol_type ten);
      case (d)
         1, 2, 3: repeat (d) syms.push_back(one);
         4: begin
            syms.push_back(one);
            syms.push_back(five);
         end
         5: syms.push_back(five);
         6, 7, 8: begin
            syms.push_back(five);
            repeat (d - 5) syms.push_back(one);
         end
         9: begin
            syms.push_back(one);
            syms.push_back(ten);
         end
         default: ;
      endcase
   endfunction

   // queue the characters that a value converts to
   function automatic void predict_numeral(input value_type v);
      symbol_type syms[$];
      int         n;
      n = int'(v);
      if (v == '0 || v > VALUE_MAX) begin
         numeral_chars.push_back('{CH_NONE, 1'b1, 1'b1});
      end else begin
         repeat (n / 1000) syms.push_back(CH_M);
         add_digit(syms, (n % 1000) / 100, CH_C, CH_D, CH_M);
         add_digit(syms, (n % 100) / 10, CH_X, CH_L, CH_C);
         add_digit(syms, n % 10, CH_I, CH_V, CH_X);
         foreach (syms[i])
            numeral_chars.push_back('{syms[i], logic'(i == syms.size() - 1), 1'b0});
      end
   endfunction

   // queue a numeral typed in by hand; "#" stands for the error item
   function automatic void expect_text(input string text);
      if (text == "#") begin
         numeral_chars.push_back('{CH_NONE, 1'b1, 1'b1});
      end else begin
         for (int i = 0; i < text.len(); i++)
            numeral_chars.push_back('{symbol_type'(text[i]),
                                      logic'(i == text.len() - 1), 1'b0});
      end
   endfunction

   // offer one value, hold it until taken, then queue what it must produce
   task automatic send_value(input value_type v, input string text);
      if (!no_stall && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth - ValueWidth){1'b0}}, v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (text == "") predict_numeral(v);
      else            expect_text(text);
      values_sent++;
      if (v == '0 || v > VALUE_MAX) oor_sent++;
   endtask

   // receiver back-pressure
   always @(posedge clock)
      rsp_tready <= no_stall || ($urandom_range(99) >= 9);

   // result checker
   always @(posedge clock) begin : check_rsp
      numeral_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_seen++;
         if (numeral_chars.size() == 0) begin
            mismatches++;
            $display("%0t: character 0x%h arrived with none expected", $time, rsp_tdata);
         end else begin
            want = numeral_chars.pop_front();
            if (rsp_tdata !== want.symbol) begin
               mismatches++;
               $display("%0t: symbol expected 0x%h got 0x%h", $time, want.symbol, rsp_tdata);
            end
            if (rsp_tlast !== want.last) begin
               mismatches++;
               $display("%0t: last expected %b got %b", $time, want.last, rsp_tlast);
            end
            if (rsp_tuser !== want.oor) begin
               mismatches++;
               $display("%0t: out_of_range expected %b got %b", $time, want.oor, rsp_tuser);
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      value_type v;
      int        r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      no_stall   = 1'b0;
      mismatches = 0;
      values_sent = 0;
      oor_sent   = 0;
      chars_seen = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < NumRows; i++)
         send_value(row_value[i], row_text[i]);

      // random values, mostly in range, with a stall-free window in the middle
      for (int i = 0; i < RandomItems; i++) begin
         no_stall = (i >= 60 && i < 100);
         r = $urandom_range(99);
         if (r < 4)       v = '0;
         else if (r < 10) v = value_type'($urandom_range(4000, 4095));
         else if (r < 20) v = value_type'($urandom_range(3000, 3999));
         else             v = value_type'($urandom_range(1, 3999));
         send_value(v, "");
      end
      no_stall = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then allow a few spare cycles for anything stray
      while (numeral_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Converted %0d values (%0d out of range); %0d characters checked.",
               values_sent, oor_sent, chars_seen);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== binary_to_roman_numeral.f =====
sv/b2r_pkg.sv
sv/b2r_dp.sv
sv/b2r_ctrl.sv
sv/binary_to_roman_numeral.sv
sv/b2r_check.sv
verif/binary_to_roman_numeral_tb.sv
